/* rtl/naive_pattern_search_macros.svh */
//------------------------------------------------------------------------------
// naive_pattern_search_macros.svh
// Assertion macros shared by the pattern search RTL.
//------------------------------------------------------------------------------
`ifndef NAIVE_PATTERN_SEARCH_MACROS_SVH
`define NAIVE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/nps_pkg.sv */
//------------------------------------------------------------------------------
// nps_pkg
// Types and constants of the streaming naive pattern search block.
//------------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  localparam int POS_W     = 20;
  localparam int CMP_W     = 26;
  localparam int PLEN_W    = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMP_W-1:0] CMP_LIMIT = {CMP_W{1'b1}};

  // Input item modes.
  localparam logic [1:0] MODE_PATTERN = 2'd0;
  localparam logic [1:0] MODE_TEXT    = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ALL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 2'd1;

  // Result kinds.
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last_text;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic [CMP_W-1:0] comparisons;
    logic             found;
    logic             final_res;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/naive_pattern_search.sv */
//------------------------------------------------------------------------------
// naive_pattern_search
// Streaming naive string matcher with a parallel window compare.
//------------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall is low. An accepted
// item sits in the input register, where the whole window is compared with the
// stored pattern at once, and its results go into a four-entry result queue
// that the output channel drains. A result goes from the input register into
// the queue and is offered on the output from there. A match on the byte
// marked last_text makes two results, so the input register only moves on
// when the queue has two free entries. With the output never stalled the
// block takes an item every cycle; only runs of items that each cause two
// results make it stall while the queue drains. No clearing pass runs after
// reset.
`default_nettype none

`include "naive_pattern_search_macros.svh"

module naive_pattern_search
  import nps_pkg::*;
#(
  parameter int PATTERN_MAX = 32,
  parameter int TEXT_MAX    = 1048576
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire in_item_t             in_data,
  // Result channel
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      out_item_t            out_data,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PLEN_W-1:0]    cfg_data
);

  localparam int PW         = $clog2(PATTERN_MAX + 1);
  localparam int IW         = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int TCW        = $clog2(TEXT_MAX + 1);
  localparam int WIN_W      = PATTERN_MAX * 8;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Configuration
  logic              match_all_r;
  logic [PLEN_W-1:0] plen_r;

  // Search state
  logic [7:0]        pat_r [PATTERN_MAX];
  logic [7:0]        win_r [PATTERN_MAX];
  logic [PW-1:0]     pfill_r;
  logic [TCW-1:0]    tc_r;
  logic [CMP_W-1:0]  total_r;
  logic              seen_r;

  // Input register
  logic              s1_valid_r;
  in_item_t          s1_data_r;

  // Result queue
  out_item_t            fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_CW-1:0]   fifo_cnt_r;

  logic in_acc;
  logic s1_go;
  logic pop;

  // Stage compute signals
  logic              is_pat;
  logic              is_clr;
  logic              is_txt;
  logic              text_ok;
  logic [PW-1:0]     len;
  logic [PW-1:0]     shamt;
  logic [WIN_W-1:0]  cur_vec;
  logic [WIN_W-1:0]  aligned;
  logic [PATTERN_MAX-1:0] eq;
  logic [PW-1:0]     ff;
  logic              fz;
  logic              full;
  logic [TCW-1:0]    tc_new;
  logic              do_cmp;
  logic              hit;
  logic [PW-1:0]     add_n;
  logic [CMP_W:0]    sum;
  logic [CMP_W-1:0]  total_nxt;
  logic              seen_nxt;
  logic [TCW-1:0]    start;
  out_item_t         e0;
  out_item_t         e1;
  logic [1:0]        push_n;

  assign cfg_ready = 1'b1;

  // Input handshake: the input register moves on once the queue has room
  // for the two results one item may cause.
  assign s1_go    = s1_valid_r && (fifo_cnt_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid = (fifo_cnt_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    is_pat  = (s1_data_r.mode == MODE_PATTERN);
    is_clr  = (s1_data_r.mode == MODE_CLEAR);
    is_txt  = (s1_data_r.mode == MODE_TEXT);
    text_ok = (tc_r < TCW'(TEXT_MAX));

    // Effective pattern length: zero acts as one, clamped to the store size.
    if (plen_r == '0) begin
      len = PW'(1);
    end else if (PW'(plen_r) > PW'(PATTERN_MAX) ||
                 (PLEN_W > PW && plen_r > PLEN_W'(PATTERN_MAX))) begin
      len = PW'(PATTERN_MAX);
    end else begin
      len = PW'(plen_r);
    end
  end

  // Window as it stands after this text byte, oldest entry at the bottom.
  // Shifting down by the unused depth lines the last len bytes up with the
  // pattern, oldest byte against pattern byte zero.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i == PATTERN_MAX - 1) begin
        cur_vec[i*8 +: 8] = s1_data_r.data_byte;
      end else begin
        cur_vec[i*8 +: 8] = win_r[i+1];
      end
    end
    shamt   = PW'(PATTERN_MAX) - len;
    aligned = cur_vec >> {shamt, 3'b000};
    for (int m = 0; m < PATTERN_MAX; m++) begin
      eq[m] = (aligned[m*8 +: 8] == pat_r[m]) || (PW'(m) >= len);
    end
    full = &eq;
    ff   = '0;
    fz   = 1'b0;
    for (int m = 0; m < PATTERN_MAX; m++) begin
      if (!eq[m] && !fz) begin
        ff = PW'(m);
        fz = 1'b1;
      end
    end
  end

  always_comb begin
    tc_new = tc_r + TCW'(1);
    do_cmp = is_txt && text_ok && (tc_new >= TCW'(len)) && !(!match_all_r && seen_r);
    hit    = do_cmp && full;
    add_n  = full ? len : ff + PW'(1);
    sum    = {1'b0, total_r} + (CMP_W + 1)'(add_n);
    if (!do_cmp) begin
      total_nxt = total_r;
    end else if (sum > {1'b0, CMP_LIMIT}) begin
      total_nxt = CMP_LIMIT;
    end else begin
      total_nxt = sum[CMP_W-1:0];
    end
    seen_nxt = seen_r || hit;
    start    = tc_new - TCW'(len);

    e0.kind        = KIND_MATCH;
    e0.position    = POS_W'(start);
    e0.comparisons = total_nxt;
    e0.found       = 1'b1;
    e0.final_res   = !s1_data_r.last_text;

    e1.kind        = KIND_SUMMARY;
    e1.position    = '0;
    e1.comparisons = total_nxt;
    e1.found       = seen_nxt;
    e1.final_res   = 1'b1;

    push_n = 2'd0;
    if (s1_go && is_txt) begin
      if (hit && s1_data_r.last_text) begin
        push_n = 2'd2;
      end else if (hit) begin
        push_n = 2'd1;
      end else if (s1_data_r.last_text) begin
        push_n = 2'd1;
        e0     = e1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_all_r <= 1'b1;
      plen_r      <= PLEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MATCH_ALL:   match_all_r <= cfg_data[0];
        CFG_PATTERN_LEN: plen_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !s1_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
  end

  // Search control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfill_r <= '0;
      tc_r    <= '0;
      total_r <= '0;
      seen_r  <= 1'b0;
    end else if (s1_go) begin
      if (is_clr) begin
        pfill_r <= '0;
        tc_r    <= '0;
        total_r <= '0;
        seen_r  <= 1'b0;
      end else if (is_pat) begin
        if (pfill_r < PW'(PATTERN_MAX)) begin
          pfill_r <= pfill_r + PW'(1);
        end
      end else if (is_txt && text_ok) begin
        tc_r    <= tc_new;
        total_r <= total_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  // Pattern store and text window
  always_ff @(posedge clk) begin
    if (s1_go && is_pat && (pfill_r < PW'(PATTERN_MAX))) begin
      pat_r[pfill_r[IW-1:0]] <= s1_data_r.data_byte;
    end
    if (s1_go && is_txt && text_ok) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win_r[i] <= cur_vec[i*8 +: 8];
      end
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      wr_ptr_r   <= wr_ptr_r + FIFO_AW'(push_n);
      rd_ptr_r   <= rd_ptr_r + FIFO_AW'(pop);
      fifo_cnt_r <= fifo_cnt_r + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= e0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= e1;
    end
  end

  // In first-match mode a match is only reported while none has been seen.
  `NPS_ASSERT_NOW(a_first_match_once, hit && !match_all_r, !seen_r, "repeated first match")
  // The comparison total only moves up between new searches.
  `NPS_ASSERT_NEXT(a_total_monotonic, s1_go && !is_clr, total_r >= $past(total_r), "total fell")
  // The queue never holds more results than it has entries.
  `NPS_ASSERT_NEXT(a_queue_bound, push_n != 2'd0, fifo_cnt_r <= FIFO_CW'(FIFO_DEPTH), "queue overflow")

endmodule

`default_nettype wire
